>>> rtl/assert_macros.svh
// Assertion macros used by the RTL controller lgs_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge once reset is released.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

>>> rtl/lgs_pkg.sv
// Shared constants, codes and types of the life grid generation step block.
package lgs_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int CFG_W       = 7;
  localparam int CNT_W       = 4;

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_ADVANCE = 2'd2;

  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  localparam logic [CNT_W-1:0] BIRTH_COUNT = CNT_W'(3);
  localparam logic [CNT_W-1:0] STAY_COUNT  = CNT_W'(2);

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_CELL,
    ACC_GEN
  } acc_kind_e;

  typedef struct packed {
    acc_kind_e        kind;
    logic [ROW_W-1:0] row;
  } lgs_sts_t;

  typedef struct packed {
    logic             latch;
    logic             respond;
    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
    logic             cell_op;
    logic             gen_load;
    logic             gen_step;
    logic [ROW_W-1:0] row;
  } lgs_cmd_t;

endpackage

>>> rtl/life_grid_generation_step.sv
// Top level of the life grid generation step block (B3/S23 on a bounded grid).
//
// Command channel: present mode_i, column_i, row_i and cell_value_i with start; the
// transaction is taken at a rising edge where start is high and busy is low.
// Result channel: done_o is high for exactly one cycle with cell_alive_o and
// out_of_range_o; the receiver cannot stall, so the result is taken in that cycle.
// Configuration channel: cfg_valid_i / cfg_ready_o with cfg_index_i (0 columns in use,
// 1 rows in use) and cfg_data_i; cfg_ready_o is always high. Write only while idle.
// Responses: an access outside the active area or an unused mode answers in the cycle
// after acceptance with busy staying low; a cell read or write answers through the
// registered memory read and then the S_CELL state; an advance walks all MAX_ROWS
// grid rows, one memory read and one write per grid row on a row memory with one
// read port and one write port.
// A new command is taken in the cycle after busy falls.
// Reset: asynchronous, active low; the grid reads as all dead through per-row valid
// bits, both size registers return to 64, and no result is pending.
module life_grid_generation_step (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                mode_i,
  input  logic [lgs_pkg::COL_W-1:0] column_i,
  input  logic [lgs_pkg::ROW_W-1:0] row_i,
  input  logic                      cell_value_i,
  output logic                      done_o,
  output logic                      cell_alive_o,
  output logic                      out_of_range_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_index_i,
  input  logic [lgs_pkg::CFG_W-1:0] cfg_data_i
);

  lgs_pkg::lgs_cmd_t cmd;
  lgs_pkg::lgs_sts_t sts;

  assign cfg_ready_o = 1'b1;

  lgs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  lgs_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .mode_i         (mode_i),
    .column_i       (column_i),
    .row_i          (row_i),
    .cell_value_i   (cell_value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .done_o         (done_o),
    .cell_alive_o   (cell_alive_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

>>> rtl/lgs_dpath.sv
// Datapath: configuration registers, grid memory, saved rows and the B3/S23 row logic.
module lgs_dpath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [lgs_pkg::CFG_W-1:0] cfg_data_i,
  input  logic [1:0]                mode_i,
  input  logic [lgs_pkg::COL_W-1:0] column_i,
  input  logic [lgs_pkg::ROW_W-1:0] row_i,
  input  logic                      cell_value_i,
  input  lgs_pkg::lgs_cmd_t         cmd_i,
  output lgs_pkg::lgs_sts_t         sts_o,
  output logic                      done_o,
  output logic                      cell_alive_o,
  output logic                      out_of_range_o
);

  logic [lgs_pkg::CFG_W-1:0]       cols_cfg_q, rows_cfg_q;
  logic [lgs_pkg::CFG_W-1:0]       cols_eff, rows_eff;
  logic [lgs_pkg::MAX_COLUMNS-1:0] col_mask;
  logic                            oor_in;

  logic [1:0]                      mode_q;
  logic [lgs_pkg::COL_W-1:0]       col_q;
  logic [lgs_pkg::ROW_W-1:0]       row_q;
  logic                            val_q;

  logic [lgs_pkg::MAX_COLUMNS-1:0] mem_q [lgs_pkg::MAX_ROWS];
  logic [lgs_pkg::MAX_ROWS-1:0]    row_vld_q;
  logic [lgs_pkg::MAX_COLUMNS-1:0] rd_data_q;
  logic                            rd_vld_q;
  logic [lgs_pkg::MAX_COLUMNS-1:0] rd_row;

  logic [lgs_pkg::MAX_COLUMNS-1:0] above_q, above_d, cur_q, cur_d;
  logic [lgs_pkg::MAX_COLUMNS-1:0] below, next_row, cell_row;
  logic [lgs_pkg::MAX_COLUMNS-1:0] a_l, a_r, c_l, c_r, b_l, b_r;
  logic                            row_live;

  logic                            wr_en;
  logic [lgs_pkg::ROW_W-1:0]       wr_addr;
  logic [lgs_pkg::MAX_COLUMNS-1:0] wr_data;

  logic                            done_q, alive_q, oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= lgs_pkg::CFG_W'(lgs_pkg::MAX_COLUMNS);
      rows_cfg_q <= lgs_pkg::CFG_W'(lgs_pkg::MAX_ROWS);
    end else if (cfg_we_i) begin
      if (cfg_index_i == lgs_pkg::REG_COLUMNS) begin
        cols_cfg_q <= cfg_data_i;
      end
      if (cfg_index_i == lgs_pkg::REG_ROWS) begin
        rows_cfg_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    if (cols_cfg_q == '0) begin
      cols_eff = lgs_pkg::CFG_W'(1);
    end else if (cols_cfg_q > lgs_pkg::CFG_W'(lgs_pkg::MAX_COLUMNS)) begin
      cols_eff = lgs_pkg::CFG_W'(lgs_pkg::MAX_COLUMNS);
    end else begin
      cols_eff = cols_cfg_q;
    end
    if (rows_cfg_q == '0) begin
      rows_eff = lgs_pkg::CFG_W'(1);
    end else if (rows_cfg_q > lgs_pkg::CFG_W'(lgs_pkg::MAX_ROWS)) begin
      rows_eff = lgs_pkg::CFG_W'(lgs_pkg::MAX_ROWS);
    end else begin
      rows_eff = rows_cfg_q;
    end
  end

  for (genvar c = 0; c < lgs_pkg::MAX_COLUMNS; c++) begin : g_mask
    assign col_mask[c] = lgs_pkg::CFG_W'(c) < cols_eff;
  end

  always_comb begin
    oor_in = 1'b0;
    if (mode_i == lgs_pkg::MODE_WRITE || mode_i == lgs_pkg::MODE_READ) begin
      oor_in = (lgs_pkg::CFG_W'(column_i) >= cols_eff) ||
               (lgs_pkg::CFG_W'(row_i) >= rows_eff);
    end
    sts_o.row = row_i;
    if (mode_i == lgs_pkg::MODE_ADVANCE) begin
      sts_o.kind = lgs_pkg::ACC_GEN;
    end else if ((mode_i == lgs_pkg::MODE_WRITE || mode_i == lgs_pkg::MODE_READ) && !oor_in) begin
      sts_o.kind = lgs_pkg::ACC_CELL;
    end else begin
      sts_o.kind = lgs_pkg::ACC_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= mode_i;
      col_q  <= column_i;
      row_q  <= row_i;
      val_q  <= cell_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_vld_q <= row_vld_q[cmd_i.rd_addr];
      end
    end
  end

  assign rd_row = rd_vld_q ? rd_data_q : '0;

  always_comb begin
    cell_row        = rd_row;
    cell_row[col_q] = val_q;
  end

  assign row_live = lgs_pkg::CFG_W'(cmd_i.row) < rows_eff;
  assign below    = ((lgs_pkg::CFG_W'(cmd_i.row) + lgs_pkg::CFG_W'(1)) < rows_eff) ?
                    (rd_row & col_mask) : '0;

  assign a_l = above_q << 1;
  assign a_r = above_q >> 1;
  assign c_l = cur_q << 1;
  assign c_r = cur_q >> 1;
  assign b_l = below << 1;
  assign b_r = below >> 1;

  always_comb begin
    logic [lgs_pkg::CNT_W-1:0] n;
    for (int c = 0; c < lgs_pkg::MAX_COLUMNS; c++) begin
      n = lgs_pkg::CNT_W'(a_l[c]) + lgs_pkg::CNT_W'(above_q[c]) + lgs_pkg::CNT_W'(a_r[c]) +
          lgs_pkg::CNT_W'(c_l[c]) + lgs_pkg::CNT_W'(c_r[c]) +
          lgs_pkg::CNT_W'(b_l[c]) + lgs_pkg::CNT_W'(below[c]) + lgs_pkg::CNT_W'(b_r[c]);
      next_row[c] = row_live && col_mask[c] &&
                    ((n == lgs_pkg::BIRTH_COUNT) || (cur_q[c] && n == lgs_pkg::STAY_COUNT));
    end
  end

  always_comb begin
    above_d = above_q;
    cur_d   = cur_q;
    if (cmd_i.gen_load) begin
      above_d = '0;
      cur_d   = rd_row & col_mask;
    end else if (cmd_i.gen_step) begin
      above_d = cur_q;
      cur_d   = below;
    end
  end

  always_ff @(posedge clk_i) begin
    above_q <= above_d;
    cur_q   <= cur_d;
  end

  assign wr_en   = (cmd_i.cell_op && mode_q == lgs_pkg::MODE_WRITE) || cmd_i.gen_step;
  assign wr_addr = cmd_i.gen_step ? cmd_i.row : row_q;
  assign wr_data = cmd_i.gen_step ? next_row : cell_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.respond;
    end
  end

  always_ff @(posedge clk_i) begin
    alive_q <= cmd_i.cell_op && mode_q == lgs_pkg::MODE_READ && rd_row[col_q];
    oor_q   <= cmd_i.latch && oor_in;
  end

  assign done_o         = done_q;
  assign cell_alive_o   = alive_q & done_q;
  assign out_of_range_o = oor_q & done_q;

endmodule

>>> rtl/lgs_ctrl.sv
// Controller: sequences cell accesses and the row walk of one generation.
`include "assert_macros.svh"

module lgs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lgs_pkg::lgs_sts_t sts_i,
  output lgs_pkg::lgs_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_CELL     = 2'd1;
  localparam logic [1:0] S_GEN_LOAD = 2'd2;
  localparam logic [1:0] S_GEN_ROW  = 2'd3;

  localparam logic [lgs_pkg::ROW_W-1:0] LastRow = lgs_pkg::ROW_W'(lgs_pkg::MAX_ROWS - 1);

  logic [1:0]                state_q, state_d;
  logic [lgs_pkg::ROW_W-1:0] cnt_q, cnt_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          unique case (sts_i.kind)
            lgs_pkg::ACC_CELL: begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_addr = sts_i.row;
              state_d       = S_CELL;
            end
            lgs_pkg::ACC_GEN: begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_addr = '0;
              cnt_d         = '0;
              state_d       = S_GEN_LOAD;
            end
            default: begin
              cmd_o.respond = 1'b1;
            end
          endcase
        end
      end
      S_CELL: begin
        cmd_o.cell_op = 1'b1;
        cmd_o.respond = 1'b1;
        state_d       = S_IDLE;
      end
      S_GEN_LOAD: begin
        cmd_o.gen_load = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_addr  = lgs_pkg::ROW_W'(1);
        state_d        = S_GEN_ROW;
      end
      S_GEN_ROW: begin
        cmd_o.gen_step = 1'b1;
        cmd_o.row      = cnt_q;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_addr  = cnt_q + lgs_pkg::ROW_W'(2);
        if (cnt_q == LastRow) begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cnt_d = cnt_q + lgs_pkg::ROW_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy = state_q != S_IDLE;

  `ASSERT_RST(a_gen_respond_last, clk_i, rst_ni, (state_q == S_GEN_ROW && cmd_o.respond) |-> (cnt_q == LastRow))
  `ASSERT_RST(a_cell_one_cycle, clk_i, rst_ni, (state_q == S_CELL) |=> (state_q == S_IDLE))
  `ASSERT_RST(a_gen_starts_row0, clk_i, rst_ni, (state_q == S_GEN_LOAD) |=> (state_q == S_GEN_ROW && cnt_q == '0))
  `ASSERT_ALWAYS(a_no_write_in_idle, clk_i, (state_q == S_IDLE) |-> !(cmd_o.gen_step || cmd_o.cell_op))

endmodule

>>> dv/tb_life_grid_generation_step.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded-grid B3/S23 generation step block.
module tb_life_grid_generation_step;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         CFG_SETTLE  = 4;
  localparam int         TAIL_CYCLES = lgs_pkg::MAX_ROWS + 16;
  localparam int         WD_LIMIT    = 4000;
  localparam int         N_ITEMS     = 925;

  typedef struct packed {
    logic alive;
    logic oor;
  } cell_resp_t;

  typedef struct {
    bit                        is_cfg;
    logic                      cfg_idx;
    logic [lgs_pkg::CFG_W-1:0] cfg_val;
    logic [1:0]                mode;
    logic [lgs_pkg::COL_W-1:0] col;
    logic [lgs_pkg::ROW_W-1:0] row;
    logic                      val;
    int                        gap;
  } grid_op_t;

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      start        = 1'b0;
  logic                      busy;
  logic [1:0]                mode_i       = lgs_pkg::MODE_WRITE;
  logic [lgs_pkg::COL_W-1:0] column_i     = '0;
  logic [lgs_pkg::ROW_W-1:0] row_i        = '0;
  logic                      cell_value_i = 1'b0;
  logic                      done_o;
  logic                      cell_alive_o;
  logic                      out_of_range_o;
  logic                      cfg_valid_i  = 1'b0;
  logic                      cfg_ready_o;
  logic                      cfg_index_i  = lgs_pkg::REG_COLUMNS;
  logic [lgs_pkg::CFG_W-1:0] cfg_data_i   = '0;

  life_grid_generation_step u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .column_i       (column_i),
    .row_i          (row_i),
    .cell_value_i   (cell_value_i),
    .done_o         (done_o),
    .cell_alive_o   (cell_alive_o),
    .out_of_range_o (out_of_range_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [lgs_pkg::MAX_COLUMNS-1:0] life_grid [lgs_pkg::MAX_ROWS];
  logic [lgs_pkg::CFG_W-1:0]       cols_cfg = lgs_pkg::CFG_W'(64);
  logic [lgs_pkg::CFG_W-1:0]       rows_cfg = lgs_pkg::CFG_W'(64);

  grid_op_t   op_q[$];
  cell_resp_t answer_q[$];

  int err_cnt      = 0;
  int n_cmd        = 0;
  int n_gen        = 0;
  int n_live       = 0;
  int n_oor        = 0;
  int n_cfg_wr     = 0;
  int gap_cnt      = 0;
  int idle_cnt     = 0;
  int stall_cycles = 0;
  int planned      = 0;
  int plan_cols    = 64;
  int plan_rows    = 64;
  bit calm         = 1'b0;

  function automatic int active_extent(logic [lgs_pkg::CFG_W-1:0] v, int lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic void step_generation();
    int cols, rows, n, rr, cc;
    logic [lgs_pkg::MAX_COLUMNS-1:0] prev [lgs_pkg::MAX_ROWS];
    cols = active_extent(cols_cfg, lgs_pkg::MAX_COLUMNS);
    rows = active_extent(rows_cfg, lgs_pkg::MAX_ROWS);
    for (int r = 0; r < lgs_pkg::MAX_ROWS; r++) prev[r] = (r < rows) ? life_grid[r] : '0;
    for (int r = 0; r < lgs_pkg::MAX_ROWS; r++) begin
      for (int c = 0; c < lgs_pkg::MAX_COLUMNS; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && rr < rows && cc >= 0 && cc < cols)
              n += prev[rr][cc];
          end
        end
        if (r >= rows || c >= cols) life_grid[r][c] = 1'b0;
        else if (prev[r][c])
          life_grid[r][c] = (n == lgs_pkg::STAY_COUNT || n == lgs_pkg::BIRTH_COUNT);
        else life_grid[r][c] = (n == lgs_pkg::BIRTH_COUNT);
      end
    end
  endfunction

  function automatic cell_resp_t apply_life_op(logic [1:0] mode,
                                               logic [lgs_pkg::COL_W-1:0] col,
                                               logic [lgs_pkg::ROW_W-1:0] row, logic val);
    cell_resp_t res;
    int cols, rows;
    res  = '0;
    cols = active_extent(cols_cfg, lgs_pkg::MAX_COLUMNS);
    rows = active_extent(rows_cfg, lgs_pkg::MAX_ROWS);
    if (mode == lgs_pkg::MODE_WRITE || mode == lgs_pkg::MODE_READ) begin
      if (int'(col) >= cols || int'(row) >= rows) res.oor = 1'b1;
      else if (mode == lgs_pkg::MODE_WRITE) life_grid[row][col] = val;
      else res.alive = life_grid[row][col];
    end else if (mode == lgs_pkg::MODE_ADVANCE) begin
      step_generation();
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int p;
    if (calm) return 0;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int pick_extent();
    int p;
    p = $urandom_range(99);
    if (p < 4) return 0;
    if (p < 8) return $urandom_range(2, 1);
    if (p < 12) return $urandom_range(127, 65);
    if (p < 16) return 64;
    if (p < 72) return $urandom_range(12, 3);
    if (p < 88) return $urandom_range(40, 13);
    return $urandom_range(63, 41);
  endfunction

  task automatic push_cmd(logic [1:0] m, int c, int r, logic v);
    grid_op_t op;
    op.is_cfg  = 1'b0;
    op.cfg_idx = lgs_pkg::REG_COLUMNS;
    op.cfg_val = '0;
    op.mode    = m;
    op.col     = lgs_pkg::COL_W'(c);
    op.row     = lgs_pkg::ROW_W'(r);
    op.val     = v;
    op.gap     = pick_gap();
    op_q.push_back(op);
    planned++;
  endtask

  task automatic push_cfg(logic idx, int v);
    grid_op_t op;
    op.is_cfg  = 1'b1;
    op.cfg_idx = idx;
    op.cfg_val = lgs_pkg::CFG_W'(v);
    op.mode    = lgs_pkg::MODE_WRITE;
    op.col     = '0;
    op.row     = '0;
    op.val     = 1'b0;
    op.gap     = 0;
    op_q.push_back(op);
    if (idx == lgs_pkg::REG_COLUMNS)
      plan_cols = active_extent(lgs_pkg::CFG_W'(v), lgs_pkg::MAX_COLUMNS);
    else plan_rows = active_extent(lgs_pkg::CFG_W'(v), lgs_pkg::MAX_ROWS);
  endtask

  task automatic push_inside(logic [1:0] m, logic v);
    push_cmd(m, $urandom_range(plan_cols - 1), $urandom_range(plan_rows - 1), v);
  endtask

  task automatic push_outside(logic [1:0] m);
    int c, r;
    c = $urandom_range(63);
    r = $urandom_range(63);
    if (plan_cols < lgs_pkg::MAX_COLUMNS &&
        (plan_rows == lgs_pkg::MAX_ROWS || $urandom_range(1) == 0))
      c = $urandom_range(63, plan_cols);
    else if (plan_rows < lgs_pkg::MAX_ROWS)
      r = $urandom_range(63, plan_rows);
    push_cmd(m, c, r, 1'($urandom_range(1)));
  endtask

  // driver: commands and register writes, one nonblocking update per signal per edge
  always @(posedge clk_i) begin
    logic     s_nxt, v_nxt;
    grid_op_t op;
    if (rst_ni) begin
      s_nxt = start;
      v_nxt = cfg_valid_i;
      if (start && !busy) begin
        answer_q.push_back(apply_life_op(mode_i, column_i, row_i, cell_value_i));
        n_cmd++;
        if (mode_i == lgs_pkg::MODE_ADVANCE) n_gen++;
        s_nxt   = 1'b0;
        gap_cnt = 0;
      end else if (!start) begin
        gap_cnt++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == lgs_pkg::REG_COLUMNS) cols_cfg = cfg_data_i;
        else rows_cfg = cfg_data_i;
        n_cfg_wr++;
        v_nxt = 1'b0;
      end
      if (!s_nxt && !v_nxt && !busy && answer_q.size() == 0) idle_cnt++;
      else idle_cnt = 0;
      if (!s_nxt && !v_nxt && op_q.size() != 0) begin
        op = op_q[0];
        if (op.is_cfg) begin
          if (idle_cnt >= CFG_SETTLE) begin
            v_nxt = 1'b1;
            cfg_index_i <= op.cfg_idx;
            cfg_data_i  <= op.cfg_val;
            void'(op_q.pop_front());
          end
        end else if (gap_cnt >= op.gap) begin
          s_nxt = 1'b1;
          mode_i       <= op.mode;
          column_i     <= op.col;
          row_i        <= op.row;
          cell_value_i <= op.val;
          void'(op_q.pop_front());
        end
      end
      start       <= s_nxt;
      cfg_valid_i <= v_nxt;
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    cell_resp_t want;
    if (rst_ni && done_o !== 1'b0) begin
      if (answer_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result: expected none, got alive=%0b oor=%0b",
                 $time, cell_alive_o, out_of_range_o);
      end else begin
        want = answer_q.pop_front();
        if (want.alive) n_live++;
        if (want.oor) n_oor++;
        if (cell_alive_o !== want.alive) begin
          err_cnt++;
          $display("%0t: cell_alive mismatch: expected %0b, got %0b",
                   $time, want.alive, cell_alive_o);
        end
        if (out_of_range_o !== want.oor) begin
          err_cnt++;
          $display("%0t: out_of_range mismatch: expected %0b, got %0b",
                   $time, want.oor, out_of_range_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || done_o === 1'b1)
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WD_LIMIT) begin
        $display("%0t: watchdog: no transaction for %0d cycles", $time, stall_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int k, gens, density, p;
    for (int r = 0; r < lgs_pkg::MAX_ROWS; r++) life_grid[r] = '0;

    push_cmd(lgs_pkg::MODE_READ, 0, 0, 1'b1);
    push_cmd(lgs_pkg::MODE_READ, 63, 63, 1'b0);
    push_cmd(lgs_pkg::MODE_WRITE, 63, 63, 1'b1);
    push_cmd(lgs_pkg::MODE_READ, 63, 63, 1'b0);
    push_cmd(lgs_pkg::MODE_WRITE, 0, 0, 1'b1);
    push_cmd(lgs_pkg::MODE_READ, 0, 0, 1'b0);
    push_cmd(MODE_UNUSED, 63, 0, 1'b1);
    push_cmd(lgs_pkg::MODE_ADVANCE, 0, 63, 1'b0);
    push_cmd(lgs_pkg::MODE_READ, 63, 63, 1'b1);
    push_cmd(lgs_pkg::MODE_READ, 0, 0, 1'b0);
    push_cfg(lgs_pkg::REG_COLUMNS, 3);
    push_cfg(lgs_pkg::REG_ROWS, 3);
    push_cmd(lgs_pkg::MODE_WRITE, 1, 0, 1'b1);
    push_cmd(lgs_pkg::MODE_WRITE, 1, 1, 1'b1);
    push_cmd(lgs_pkg::MODE_WRITE, 1, 2, 1'b1);
    push_cmd(lgs_pkg::MODE_ADVANCE, 0, 0, 1'b0);
    push_cmd(lgs_pkg::MODE_READ, 0, 1, 1'b0);
    push_cmd(lgs_pkg::MODE_READ, 1, 1, 1'b0);
    push_cmd(lgs_pkg::MODE_READ, 2, 1, 1'b0);
    push_cmd(lgs_pkg::MODE_READ, 1, 0, 1'b0);
    push_cmd(lgs_pkg::MODE_WRITE, 3, 0, 1'b1);
    push_cmd(lgs_pkg::MODE_READ, 0, 3, 1'b0);
    push_cfg(lgs_pkg::REG_COLUMNS, 0);
    push_cfg(lgs_pkg::REG_ROWS, 127);
    push_cmd(lgs_pkg::MODE_WRITE, 0, 5, 1'b1);
    push_cmd(lgs_pkg::MODE_READ, 0, 5, 1'b0);
    push_cmd(lgs_pkg::MODE_WRITE, 1, 0, 1'b1);
    push_cmd(lgs_pkg::MODE_ADVANCE, 63, 63, 1'b1);
    push_cmd(lgs_pkg::MODE_READ, 0, 5, 1'b0);

    while (planned < N_ITEMS) begin
      calm = ($urandom_range(9) < 3);
      if ($urandom_range(4) != 0) push_cfg(lgs_pkg::REG_COLUMNS, pick_extent());
      if ($urandom_range(4) != 0) push_cfg(lgs_pkg::REG_ROWS, pick_extent());
      k = $urandom_range(2);
      repeat (k) push_inside(lgs_pkg::MODE_READ, 1'($urandom_range(1)));
      density = $urandom_range(60, 25);
      k = $urandom_range(24, 4);
      repeat (k) push_inside(lgs_pkg::MODE_WRITE, 1'($urandom_range(99) < density));
      gens = $urandom_range(4, 1);
      repeat (gens) begin
        push_cmd(lgs_pkg::MODE_ADVANCE, $urandom_range(63), $urandom_range(63),
                 1'($urandom_range(1)));
        k = $urandom_range(8, 2);
        repeat (k) begin
          p = $urandom_range(99);
          if (p < 70) push_inside(lgs_pkg::MODE_READ, 1'($urandom_range(1)));
          else if (p < 80) push_inside(lgs_pkg::MODE_WRITE, 1'($urandom_range(1)));
          else if (p < 95) push_outside(p[0] ? lgs_pkg::MODE_WRITE : lgs_pkg::MODE_READ);
          else push_cmd(MODE_UNUSED, $urandom_range(63), $urandom_range(63),
                        1'($urandom_range(1)));
        end
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (op_q.size() != 0 || start || cfg_valid_i || answer_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (answer_q.size() != 0) begin
      err_cnt += answer_q.size();
      $display("%0t: %0d expected results never arrived", $time, answer_q.size());
    end
    $display("Covered %0d commands: %0d generations, %0d live cell reads, %0d outside area",
             n_cmd, n_gen, n_live, n_oor);
    $display("Grid size registers were rewritten %0d times", n_cfg_wr);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
